/* design/sscc_pkg.sv */
`timescale 1ns / 1ps
// shared widths, field layout, register indexes and color key for the sprite blitter
package sscc_pkg;

  // field widths
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int COLOR_W = 32;
  localparam int PIX_W   = 11;
  localparam int DIM_W   = 7;
  localparam int SIZE_W  = 12;
  localparam int ORG_W   = 12;
  localparam int SCR_W   = 10;

  // offset * dim and dim * size
  localparam int PROD_W  = PIX_W + DIM_W;
  localparam int LIM_W   = SIZE_W + DIM_W;

  // stream layout
  localparam int IN_TDATA_W   = 72;
  localparam int IN_ROW_LSB   = 0;
  localparam int IN_COL_LSB   = IN_ROW_LSB + ROW_W;
  localparam int IN_COLOR_LSB = IN_COL_LSB + COL_W;
  localparam int IN_PX_LSB    = IN_COLOR_LSB + COLOR_W;
  localparam int IN_PY_LSB    = IN_PX_LSB + PIX_W;
  localparam int IN_USED_W    = IN_PY_LSB + PIX_W;

  localparam int OUT_TDATA_W   = 56;
  localparam int OUT_COL_LSB   = 0;
  localparam int OUT_ROW_LSB   = OUT_COL_LSB + SCR_W;
  localparam int OUT_COLOR_LSB = OUT_ROW_LSB + SCR_W;
  localparam int OUT_USED_W    = OUT_COLOR_LSB + COLOR_W;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;

  // color key thresholds
  localparam logic [7:0] KEY_RED_MIN   = 8'd253;
  localparam logic [7:0] KEY_DARK_MAX  = 8'd2;
  localparam logic [7:0] DEAD_HIGH     = 8'd180;
  localparam logic [7:0] DEAD_GREEN_LT = 8'd100;

  function automatic logic is_transparent(input logic [COLOR_W-1:0] c, input logic dead);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    if (dead) begin
      return (r > DEAD_HIGH) && (b > DEAD_HIGH) && (g < DEAD_GREEN_LT);
    end
    return (r >= KEY_RED_MIN) && (g <= KEY_DARK_MAX) && (b <= KEY_DARK_MAX);
  endfunction

endpackage

/* design/sprite_scale_colorkey_clip.sv */
`timescale 1ns / 1ps
// throughput: one beat per cycle while the result stream is not stalled; each
//   restoring-division bit of the nearest-neighbor scale owns one pipeline stage,
//   and the texel store is one port shared by load and draw
// every beat, load or draw, yields exactly one result beat, in order
// reset: synchronous active-low rst_n clears the valid bits and loads the register defaults;
//   the texel store is not cleared, texels read as garbage until loaded
module sprite_scale_colorkey_clip import sscc_pkg::*; #(
  parameter int SPRITE_DIM    = 64,
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // load_row, load_col, load_color, pixel_x, pixel_y
  input  logic                   in_tuser,   // kind
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // screen_col, screen_row, pixel_color
  output logic                   out_tuser,  // write_valid
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // index width of one sprite axis, store depth and divider width
  localparam int IW    = (SPRITE_DIM > 1) ? $clog2(SPRITE_DIM) : 1;
  localparam int DEPTH = SPRITE_DIM * SPRITE_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = (PROD_W > SIZE_W + IW) ? PROD_W : SIZE_W + IW;
  localparam int ACW   = 17;  // address arithmetic, holds 255 * 256 + 255
  localparam logic [8:0] DIM9 = 9'(SPRITE_DIM);

  // one beat as it travels the front pipeline (scale and divide)
  typedef struct packed {
    logic               kind;
    logic               ld_ok;
    logic [AW-1:0]      ld_addr;
    logic [COLOR_W-1:0] ld_color;
    logic               vis;
    logic [SCR_W-1:0]   scol;
    logic [SCR_W-1:0]   srow;
    logic [DW-1:0]      rem_x;
    logic [DW-1:0]      rem_y;
    logic [LIM_W-1:0]   lim_x;
    logic [LIM_W-1:0]   lim_y;
    logic               sat_x;
    logic               sat_y;
    logic [IW-1:0]      q_x;
    logic [IW-1:0]      q_y;
  } pipe_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  sprite_width_r;
  logic [DIM_W-1:0]  sprite_height_r;
  logic [SIZE_W-1:0] draw_size_r;
  logic              dead_mode_r;
  logic [ORG_W-1:0]  origin_x_r;
  logic [ORG_W-1:0]  origin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_width_r  <= DIM_W'(64);
      sprite_height_r <= DIM_W'(64);
      draw_size_r     <= SIZE_W'(64);
      dead_mode_r     <= 1'b0;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPRITE_WIDTH:  sprite_width_r  <= cfg_data[DIM_W-1:0];
        REG_SPRITE_HEIGHT: sprite_height_r <= cfg_data[DIM_W-1:0];
        REG_DRAW_SIZE:     draw_size_r     <= cfg_data[SIZE_W-1:0];
        REG_DEAD_MODE:     dead_mode_r     <= cfg_data[0];
        REG_ORIGIN_X:      origin_x_r      <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:      origin_y_r      <= cfg_data[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sprite size: zero acts as one, capped at the store edge
  logic [DIM_W-1:0]  w_c;
  logic [DIM_W-1:0]  h_c;
  logic [SIZE_W-1:0] sz_c;
  logic [DIM_W-1:0]  wm1_c;
  logic [DIM_W-1:0]  hm1_c;

  always_comb begin
    if (sprite_width_r == '0) begin
      w_c = DIM_W'(1);
    end else if ({2'b00, sprite_width_r} > DIM9) begin
      w_c = DIM_W'(SPRITE_DIM);
    end else begin
      w_c = sprite_width_r;
    end
    if (sprite_height_r == '0) begin
      h_c = DIM_W'(1);
    end else if ({2'b00, sprite_height_r} > DIM9) begin
      h_c = DIM_W'(SPRITE_DIM);
    end else begin
      h_c = sprite_height_r;
    end
    sz_c  = (draw_size_r == '0) ? SIZE_W'(1) : draw_size_r;
    wm1_c = w_c - DIM_W'(1);
    hm1_c = h_c - DIM_W'(1);
  end

  // ---------------------------------------------------------------------------
  // handshake: each stage moves when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic [IW:0] v_r;
  logic [IW:0] mv;
  logic        mem_v_r;
  logic        mv_mem;
  logic        out_valid_r;
  logic        mv_out;

  assign mv_out = !out_valid_r || out_tready;
  assign mv_mem = !mem_v_r || mv_out;
  assign mv[IW] = !v_r[IW] || mv_mem;

  for (genvar i = 0; i < IW; i++) begin : g_mv
    assign mv[i] = !v_r[i] || mv[i+1];
  end

  assign in_tready = mv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (mv[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i <= IW; i++) begin
        if (mv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: unpack, store address, screen position, scale products
  // ---------------------------------------------------------------------------
  pipe_t st_r   [0:IW];
  pipe_t st_nxt [0:IW];

  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic [COLOR_W-1:0] in_color;
  logic [PIX_W-1:0]   in_px;
  logic [PIX_W-1:0]   in_py;
  logic [ORG_W+1:0]   xs;
  logic [ORG_W+1:0]   ys;

  assign in_row   = in_tdata[IN_ROW_LSB +: ROW_W];
  assign in_col   = in_tdata[IN_COL_LSB +: COL_W];
  assign in_color = in_tdata[IN_COLOR_LSB +: COLOR_W];
  assign in_px    = in_tdata[IN_PX_LSB +: PIX_W];
  assign in_py    = in_tdata[IN_PY_LSB +: PIX_W];

  // origin plus offset, signed; negative shows in the top bit
  assign xs = {{2{origin_x_r[ORG_W-1]}}, origin_x_r} + {3'b000, in_px};
  assign ys = {{2{origin_y_r[ORG_W-1]}}, origin_y_r} + {3'b000, in_py};

  always_comb begin
    st_nxt[0]          = '0;
    st_nxt[0].kind     = in_tuser;
    st_nxt[0].ld_ok    = ({3'b000, in_row} < DIM9) && ({3'b000, in_col} < DIM9);
    st_nxt[0].ld_addr  = AW'(ACW'(in_row) * ACW'(SPRITE_DIM) + ACW'(in_col));
    st_nxt[0].ld_color = in_color;
    st_nxt[0].vis      = !xs[ORG_W+1] && (xs < (ORG_W+2)'(SCREEN_WIDTH)) &&
                         !ys[ORG_W+1] && (ys < (ORG_W+2)'(SCREEN_HEIGHT));
    st_nxt[0].scol     = xs[SCR_W-1:0];
    st_nxt[0].srow     = ys[SCR_W-1:0];
    st_nxt[0].rem_x    = DW'(PROD_W'(in_px) * PROD_W'(w_c));
    st_nxt[0].rem_y    = DW'(PROD_W'(in_py) * PROD_W'(h_c));
    st_nxt[0].lim_x    = LIM_W'(sz_c) * LIM_W'(w_c);
    st_nxt[0].lim_y    = LIM_W'(sz_c) * LIM_W'(h_c);
  end

  always_ff @(posedge clk) begin
    if (mv[0]) begin
      st_r[0] <= st_nxt[0];
    end
  end

  // ---------------------------------------------------------------------------
  // stages 1..IW: one restoring-division bit per stage, most significant first;
  // the first also flags a quotient at or past the sprite edge
  // ---------------------------------------------------------------------------
  function automatic pipe_t div_step(input pipe_t s, input int k, input logic first,
                                     input logic [SIZE_W-1:0] sz);
    pipe_t         o;
    logic [DW-1:0] d;
    o = s;
    d = DW'(sz) << k;
    if (first) begin
      o.sat_x = ({{LIM_W{1'b0}}, s.rem_x} >= {{DW{1'b0}}, s.lim_x});
      o.sat_y = ({{LIM_W{1'b0}}, s.rem_y} >= {{DW{1'b0}}, s.lim_y});
    end
    if (s.rem_x >= d) begin
      o.rem_x = s.rem_x - d;
      o.q_x   = s.q_x | (IW'(1) << k);
    end
    if (s.rem_y >= d) begin
      o.rem_y = s.rem_y - d;
      o.q_y   = s.q_y | (IW'(1) << k);
    end
    return o;
  endfunction

  for (genvar j = 1; j <= IW; j++) begin : g_div
    assign st_nxt[j] = div_step(st_r[j-1], IW - j, (j == 1) ? 1'b1 : 1'b0, sz_c);

    always_ff @(posedge clk) begin
      if (mv[j]) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // memory stage: loads write, draws read, both in beat order on one port
  // ---------------------------------------------------------------------------
  pipe_t              last;
  logic [IW-1:0]      sx;
  logic [IW-1:0]      sy;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      ram_addr;
  logic               ram_en;
  logic               ram_we;
  logic [COLOR_W-1:0] ram_rdata;

  assign last     = st_r[IW];
  assign sx       = last.sat_x ? IW'(wm1_c) : last.q_x;
  assign sy       = last.sat_y ? IW'(hm1_c) : last.q_y;
  assign rd_addr  = AW'(ACW'(sy) * ACW'(SPRITE_DIM) + ACW'(sx));
  assign ram_addr = (last.kind == KIND_LOAD) ? last.ld_addr : rd_addr;
  assign ram_en   = v_r[IW] && mv_mem;
  assign ram_we   = (last.kind == KIND_LOAD) && last.ld_ok;

  sscc_texel_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (last.ld_color),
    .rdata (ram_rdata)
  );

  logic             mem_draw_r;
  logic             mem_vis_r;
  logic [SCR_W-1:0] mem_scol_r;
  logic [SCR_W-1:0] mem_srow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_v_r <= 1'b0;
    end else if (mv_mem) begin
      mem_v_r <= v_r[IW];
    end
  end

  always_ff @(posedge clk) begin
    if (mv_mem) begin
      mem_draw_r <= (last.kind == KIND_DRAW);
      mem_vis_r  <= last.vis;
      mem_scol_r <= last.scol;
      mem_srow_r <= last.srow;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: color key and clip; a dropped pixel reports all zeros
  // ---------------------------------------------------------------------------
  logic               wr_c;
  logic               out_wr_r;
  logic [SCR_W-1:0]   out_col_r;
  logic [SCR_W-1:0]   out_row_r;
  logic [COLOR_W-1:0] out_color_r;

  assign wr_c = mem_draw_r && mem_vis_r && !is_transparent(ram_rdata, dead_mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mv_out) begin
      out_valid_r <= mem_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_out) begin
      out_wr_r    <= wr_c;
      out_col_r   <= wr_c ? mem_scol_r : '0;
      out_row_r   <= wr_c ? mem_srow_r : '0;
      out_color_r <= wr_c ? ram_rdata  : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_wr_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_color_r, out_row_r, out_col_r};

endmodule

/* design/sscc_texel_store.sv */
`timescale 1ns / 1ps
// single-port sprite texel memory with registered read data
module sscc_texel_store import sscc_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic [COLOR_W-1:0] wdata,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [0:DEPTH-1];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/sscc_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the result stream of the sprite blitter, bound to the top level
module sscc_checker import sscc_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a dropped pixel carries no position or color
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("dropped pixel carries data");

  // a write lands on the screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((SCREEN_WIDTH > 1024) ||
       (32'(out_tdata[OUT_COL_LSB +: SCR_W]) < SCREEN_WIDTH)) &&
      ((SCREEN_HEIGHT > 1024) ||
       (32'(out_tdata[OUT_ROW_LSB +: SCR_W]) < SCREEN_HEIGHT)))
    else $error("write outside the screen");

endmodule

bind sprite_scale_colorkey_clip sscc_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_sscc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/blit_checker.sv */
`timescale 1ns / 1ps
// pixel write predictor and result comparator for the sprite blitter stream
module blit_checker import sscc_pkg::*; #(
  parameter int SPRITE_DIM    = 64,
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // load_row, load_col, load_color, pixel_x, pixel_y
  input  logic                   in_tuser,   // kind
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // screen_col, screen_row, pixel_color
  input  logic                   out_tuser,  // write_valid
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     outstanding,
  output int                     mismatches
);

  typedef struct packed {
    logic               wr;
    logic [SCR_W-1:0]   col;
    logic [SCR_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } pixel_write_t;

  logic [COLOR_W-1:0]      texels [SPRITE_DIM*SPRITE_DIM];
  logic [DIM_W-1:0]        width_q;
  logic [DIM_W-1:0]        height_q;
  logic [SIZE_W-1:0]       size_q;
  logic                    dead_q;
  logic signed [ORG_W-1:0] org_x_q;
  logic signed [ORG_W-1:0] org_y_q;
  pixel_write_t            pending_writes [$];

  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (int'(d) > SPRITE_DIM) return SPRITE_DIM;
    return int'(d);
  endfunction

  // nearest neighbor: offset * dim / size, saturating at the last texel
  function automatic int src_index(input int off, input int dim);
    int idx;
    idx = (off * dim) / ((size_q == 0) ? 1 : int'(size_q));
    if (idx >= dim) idx = dim - 1;
    return idx;
  endfunction

  function automatic logic keyed_out(input logic [COLOR_W-1:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    if (dead_q) return (r > DEAD_HIGH) && (b > DEAD_HIGH) && (g < DEAD_GREEN_LT);
    return (r >= KEY_RED_MIN) && (g <= KEY_DARK_MAX) && (b <= KEY_DARK_MAX);
  endfunction

  function automatic pixel_write_t blit_pixel(input int px, input int py);
    pixel_write_t w;
    int sx;
    int sy;
    int scol;
    int srow;
    logic [COLOR_W-1:0] c;
    w  = '0;
    sx = src_index(px, eff_dim(width_q));
    sy = src_index(py, eff_dim(height_q));
    c  = texels[(sy * SPRITE_DIM + sx) % (SPRITE_DIM * SPRITE_DIM)];
    scol = int'(org_x_q) + px;
    srow = int'(org_y_q) + py;
    if (!keyed_out(c) && scol >= 0 && scol < SCREEN_WIDTH && srow >= 0 && srow < SCREEN_HEIGHT) begin
      w.wr    = 1'b1;
      w.col   = scol[SCR_W-1:0];
      w.row   = srow[SCR_W-1:0];
      w.color = c;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    pixel_write_t want;
    pixel_write_t got;
    int row;
    int col;
    if (!rst_n) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      size_q   <= 12'd64;
      dead_q   <= 1'b0;
      org_x_q  <= '0;
      org_y_q  <= '0;
      pending_writes.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPRITE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
          REG_SPRITE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
          REG_DRAW_SIZE:     size_q   <= cfg_data[SIZE_W-1:0];
          REG_DEAD_MODE:     dead_q   <= cfg_data[0];
          REG_ORIGIN_X:      org_x_q  <= cfg_data[ORG_W-1:0];
          REG_ORIGIN_Y:      org_y_q  <= cfg_data[ORG_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_LOAD) begin
          row = int'(in_tdata[IN_ROW_LSB +: ROW_W]);
          col = int'(in_tdata[IN_COL_LSB +: COL_W]);
          if (row < SPRITE_DIM && col < SPRITE_DIM)
            texels[row * SPRITE_DIM + col] = in_tdata[IN_COLOR_LSB +: COLOR_W];
          pending_writes.push_back('0);
        end else begin
          pending_writes.push_back(blit_pixel(int'(in_tdata[IN_PX_LSB +: PIX_W]),
                                              int'(in_tdata[IN_PY_LSB +: PIX_W])));
        end
      end
      if (out_tvalid && out_tready) begin
        got.wr    = out_tuser;
        got.col   = out_tdata[OUT_COL_LSB +: SCR_W];
        got.row   = out_tdata[OUT_ROW_LSB +: SCR_W];
        got.color = out_tdata[OUT_COLOR_LSB +: COLOR_W];
        if (pending_writes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat wr=%0b col=%0d row=%0d color=%h",
                   $time, got.wr, got.col, got.row, got.color);
        end else begin
          want = pending_writes.pop_front();
          if (got.wr !== want.wr || got.col !== want.col || got.row !== want.row ||
              got.color !== want.color) begin
            mismatches++;
            $display("%0t: mismatch expected wr=%0b col=%0d row=%0d color=%h", $time,
                     want.wr, want.col, want.row, want.color);
            $display("%0t:          actual   wr=%0b col=%0d row=%0d color=%h", $time,
                     got.wr, got.col, got.row, got.color);
          end
        end
      end
      outstanding <= pending_writes.size();
    end
  end

endmodule

/* tb/sprite_scale_colorkey_clip_tb.sv */
`timescale 1ns / 1ps
// stimulus, flow control and verdict for the sprite blitter pixel stage
module sprite_scale_colorkey_clip_tb;
  import sscc_pkg::*;

  localparam int TEXEL_DIM      = 64;
  localparam int DRAIN_CYCLES   = 16;    // settle time after the last result, as slack
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int HOLD_OFF       = 150;   // long receiver stall to back up the pipe

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // load_row, load_col, load_color, pixel_x, pixel_y
  logic                   in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // screen_col, screen_row, pixel_color
  logic                   out_tuser;  // write_valid
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int outstanding;
  int mismatches;

  // mirror of the scaling registers, so draws only touch loaded texels
  int cur_w    = 64;
  int cur_h    = 64;
  int cur_size = 64;
  bit texel_loaded [TEXEL_DIM*TEXEL_DIM];

  int items_sent   = 0;
  int quiet_beats  = 0;
  int stall_cycles = 0;
  bit pressure_on   = 1'b0;
  bit pressure_done = 1'b0;

  always #5 clk = ~clk;

  sprite_scale_colorkey_clip dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  blit_checker blit_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // pack one input beat; fields that the kind ignores still carry random bits
  function automatic logic [IN_TDATA_W-1:0] beat_data(input int row, input int col,
                                                      input logic [COLOR_W-1:0] color,
                                                      input int px, input int py);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_ROW_LSB +: ROW_W]     = ROW_W'(row);
    d[IN_COL_LSB +: COL_W]     = COL_W'(col);
    d[IN_COLOR_LSB +: COLOR_W] = color;
    d[IN_PX_LSB +: PIX_W]      = PIX_W'(px);
    d[IN_PY_LSB +: PIX_W]      = PIX_W'(py);
    return d;
  endfunction

  // store address a draw at (px, py) reads under the current scaling
  function automatic int src_addr(input int px, input int py);
    int w;
    int h;
    int s;
    int sx;
    int sy;
    w  = (cur_w == 0) ? 1 : ((cur_w > TEXEL_DIM) ? TEXEL_DIM : cur_w);
    h  = (cur_h == 0) ? 1 : ((cur_h > TEXEL_DIM) ? TEXEL_DIM : cur_h);
    s  = (cur_size == 0) ? 1 : cur_size;
    sx = px * w / s;
    sy = py * h / s;
    if (sx >= w) sx = w - 1;
    if (sy >= h) sy = h - 1;
    return sy * TEXEL_DIM + sx;
  endfunction

  // sender idle: mostly none, some short, a few long, with gap-free bursts
  function automatic int next_gap();
    int r;
    if (pressure_on) return 0;
    if (quiet_beats > 0) begin
      quiet_beats--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_beats = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // colors biased toward both key regions and their edges
  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0: return {8'($urandom), 8'($urandom_range(251, 255)), 8'($urandom_range(0, 4)),
                 8'($urandom_range(0, 4))};
      1: return {8'($urandom), 8'($urandom_range(170, 255)), 8'($urandom_range(90, 110)),
                 8'($urandom_range(170, 255))};
      default: return $urandom;
    endcase
  endfunction

  // offsets mostly inside the drawn square, sometimes anywhere
  function automatic int pick_offset();
    int s;
    s = (cur_size == 0) ? 1 : cur_size;
    if (s > 2048) s = 2048;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, s - 1);
  endfunction

  // hold the beat until accepted, then maybe idle; valid stays high across gap-free beats
  task automatic send_beat(input logic kind, input logic [IN_TDATA_W-1:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_texel(input int row, input int col, input logic [COLOR_W-1:0] color);
    texel_loaded[row * TEXEL_DIM + col] = 1'b1;
    send_beat(KIND_LOAD, beat_data(row, col, color, $urandom_range(0, 2047),
                                   $urandom_range(0, 2047)));
  endtask

  // never read a texel that was not loaded: load it first with a random color
  task automatic draw_pixel(input int px, input int py);
    int a;
    a = src_addr(px, py);
    if (!texel_loaded[a]) load_texel(a / TEXEL_DIM, a % TEXEL_DIM, pick_color());
    send_beat(KIND_DRAW, beat_data($urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                                   px, py));
  endtask

  // n beats, or one more, in all, the loads that draws pull in included
  task automatic random_items(input int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(0, 3) == 0)
        load_texel($urandom_range(0, 63), $urandom_range(0, 63), pick_color());
      else
        draw_pixel(pick_offset(), pick_offset());
    end
  endtask

  // drop valid, wait for every result, then let the pipe settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called while idle: one register per cycle, all six in index order
  task automatic set_config(input int w, input int h, input int size, input int dead,
                            input int ox, input int oy);
    logic [CFG_IDX_W-1:0]  regs [6];
    logic [CFG_DATA_W-1:0] vals [6];
    regs = '{REG_SPRITE_WIDTH, REG_SPRITE_HEIGHT, REG_DRAW_SIZE, REG_DEAD_MODE,
             REG_ORIGIN_X, REG_ORIGIN_Y};
    vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(size), CFG_DATA_W'(dead),
             CFG_DATA_W'(ox), CFG_DATA_W'(oy)};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    cur_w    = w;
    cur_h    = h;
    cur_size = size;
  endtask

  // receiver: random ready pattern, plus one long hold-off once traffic is flowing
  initial begin
    int r;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!pressure_done && items_sent >= 60) begin
        // sender keeps offering with no gaps while results back up
        pressure_on = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        pressure_on   = 1'b0;
        pressure_done = 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else if (r < 6) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
    end
  end

  // watchdog: too long with no beat on either side means a hang
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= KIND_LOAD;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SPRITE_WIDTH;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: near-red key at the key edges, corners, saturated offsets
    load_texel(0, 0, 32'h00FF_0000);   // pure red, keyed out
    draw_pixel(0, 0);
    load_texel(0, 0, 32'hFFFD_0202);   // red and dark limits, keyed out
    draw_pixel(0, 0);
    load_texel(0, 0, 32'h00FC_0202);   // red one short, visible
    draw_pixel(0, 0);
    load_texel(0, 0, 32'h00FD_0302);   // green one over, visible
    draw_pixel(0, 0);
    load_texel(63, 63, 32'hFFFF_FFFF);
    draw_pixel(63, 63);
    draw_pixel(2047, 2047);            // source saturates, lands off screen
    draw_pixel(1023, 1023);            // last on-screen pixel
    load_texel(0, 63, 32'h0000_0000);
    draw_pixel(63, 0);

    // magenta-range key edges
    wait_idle();
    set_config(64, 64, 64, 1, 0, 0);
    load_texel(5, 5, 32'h00B5_63B5);   // just inside, keyed out
    draw_pixel(5, 5);
    load_texel(5, 5, 32'h00B5_64B5);   // green at limit, visible
    draw_pixel(5, 5);
    load_texel(5, 5, 32'h00B4_00FF);   // red at limit, visible
    draw_pixel(5, 5);
    load_texel(5, 5, 32'h00FF_00FF);
    draw_pixel(5, 5);
    load_texel(5, 5, 32'h00FF_0000);   // pure red is shown in this mode
    draw_pixel(5, 5);
    random_items(120);

    // zero sizes, oversize height, most negative origin: nothing visible
    wait_idle();
    set_config(0, 127, 0, 0, -2048, -2048);
    random_items(25);

    wait_idle();
    set_config(17, 5, 2048, 0, 100, -50);
    random_items(80);

    // largest draw size and origin values, origin at the far corner: all off screen
    wait_idle();
    set_config(64, 1, 4095, 1, 2047, 2047);
    random_items(20);

    wait_idle();
    set_config(33, 64, 1000, 0, -500, 200);
    random_items(80);

    repeat (4) begin
      wait_idle();
      set_config($urandom_range(0, 127), $urandom_range(0, 127),
                 $urandom_range(0, 1) ? $urandom_range(1, 160) : $urandom_range(0, 4095),
                 $urandom_range(0, 1), int'($urandom_range(0, 1200)) - 300,
                 int'($urandom_range(0, 1200)) - 300);
      random_items(55);
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sscc_pkg.sv
design/sscc_texel_store.sv
design/sprite_scale_colorkey_clip.sv
design/sscc_checker.sv
tb/blit_checker.sv
tb/sprite_scale_colorkey_clip_tb.sv
